// ===== rtl/hmtp_pkg.sv =====
package hmtp_pkg;

    localparam int HEIGHT_BITS_DEF = 16;
    localparam int SCALE_W         = 16;
    localparam int BYTE_W          = 8;
    localparam int FRAC_BITS       = 16;   // root taken over s * 2^16
    localparam int CFG_ADDR_W      = 2;

    localparam logic [CFG_ADDR_W-1:0] REG_HEIGHT_MIN = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_HEIGHT_MAX = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_VERT_SCALE = 2'd2;

    localparam logic [31:0]        HEIGHT_MIN_RESET = 32'd0;
    localparam logic [31:0]        HEIGHT_MAX_RESET = 32'd32767;
    localparam logic [SCALE_W-1:0] VERT_SCALE_RESET = 16'd1024;

    localparam logic [BYTE_W-1:0] NORMAL_BIAS = 8'd127;
    localparam logic [BYTE_W-1:0] HEIGHT_SAT  = 8'd255;

    localparam int HQ_BITS  = 8;   // height quotient bits
    localparam int NQ_BITS  = 7;   // normal quotient bits, quotient never exceeds 127
    localparam int GRAD_LAT = 4;
    localparam int NDIV_LAT = NQ_BITS + 2;
    localparam int HDIV_LAT = HQ_BITS + 4;

    typedef struct packed {
        logic advance;
        logic valid;
    } pipe_ctl_t;

    function automatic int sum_width(input int hb);
        return ((2 * hb > 2 * SCALE_W) ? 2 * hb : 2 * SCALE_W) + 2;
    endfunction

endpackage

// ===== rtl/heightmap_texel_packer_unit.sv =====
// Channel   | Handshake                     | Payload
// ----------+-------------------------------+---------------------------------------
// s_axis    | s_axis_tvalid / s_axis_tready | center, left, right, up, down heights
// m_axis    | m_axis_tvalid / m_axis_tready | height, normal x, normal z bytes
// cfg       | cfg_we                        | cfg_addr selects min, max, vertical scale
//
// One item per cycle while the output is not stalled; RB is the square root's
// bit count (25 at HEIGHT_BITS=16), one root bit per stage.
// All stages advance together; a stalled output holds the whole pipe, empty
// slots included, so input is taken whenever the output is free or taken.
// rst_n clears the valid bits and loads register reset values.
module heightmap_texel_packer_unit #(
    parameter int HEIGHT_BITS = hmtp_pkg::HEIGHT_BITS_DEF,
    parameter int CFG_W       = (HEIGHT_BITS > hmtp_pkg::SCALE_W) ? HEIGHT_BITS
                                                                   : hmtp_pkg::SCALE_W,
    parameter int IN_W        = ((5 * HEIGHT_BITS + 7) / 8) * 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [hmtp_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [CFG_W-1:0]                  cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // height_center, height_left, height_right, height_up, height_down, zero fill
    input  logic [IN_W-1:0]                   s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // height_byte, normal_x_byte, normal_z_byte
    output logic [3*hmtp_pkg::BYTE_W-1:0]     m_axis_tdata
);
    import hmtp_pkg::*;

    localparam int HB    = HEIGHT_BITS;
    localparam int SW    = sum_width(HB);
    localparam int RB    = (SW + FRAC_BITS) / 2;
    localparam int PW    = 2 * HB + 2;
    localparam int N_LAT = GRAD_LAT + RB + NDIV_LAT;
    localparam int DLY   = N_LAT - HDIV_LAT;

    logic signed [HB-1:0] hmin_reg, hmax_reg;
    logic [SCALE_W-1:0]   vscale_reg;

    pipe_ctl_t            ctl;
    logic                 advance;

    logic signed [HB-1:0] h_c, h_l, h_r, h_u, h_d;

    logic                 g_valid;
    logic [SW-1:0]        g_sum;
    logic [PW-1:0]        g_grad;
    logic                 r_valid;
    logic [RB-1:0]        r_len;
    logic [PW-1:0]        r_grad;
    logic                 n_valid;
    logic [BYTE_W-1:0]    nx_byte, nz_byte, h_byte;
    logic [BYTE_W-1:0]    hb_dly_reg [DLY];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hmin_reg   <= HEIGHT_MIN_RESET[HB-1:0];
            hmax_reg   <= HEIGHT_MAX_RESET[HB-1:0];
            vscale_reg <= VERT_SCALE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_HEIGHT_MIN: hmin_reg   <= cfg_wdata[HB-1:0];
                REG_HEIGHT_MAX: hmax_reg   <= cfg_wdata[HB-1:0];
                REG_VERT_SCALE: vscale_reg <= cfg_wdata[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    assign advance       = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = advance;
    assign ctl.advance   = advance;
    assign ctl.valid     = s_axis_tvalid;

    assign h_c = s_axis_tdata[0*HB +: HB];
    assign h_l = s_axis_tdata[1*HB +: HB];
    assign h_r = s_axis_tdata[2*HB +: HB];
    assign h_u = s_axis_tdata[3*HB +: HB];
    assign h_d = s_axis_tdata[4*HB +: HB];

    hmtp_height_div #(.HB(HB)) u_hdiv (
        .clk           (clk),
        .en            (advance),
        .height_center (h_c),
        .height_min    (hmin_reg),
        .height_max    (hmax_reg),
        .height_byte   (h_byte)
    );

    hmtp_grad #(.HB(HB), .SW(SW)) u_grad (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl_in         (ctl),
        .height_left    (h_l),
        .height_right   (h_r),
        .height_up      (h_u),
        .height_down    (h_d),
        .vertical_scale (vscale_reg),
        .out_valid      (g_valid),
        .sum_sq         (g_sum),
        .grad           (g_grad)
    );

    hmtp_isqrt #(.IW(SW), .PW(PW), .RB(RB)) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .in_valid  (g_valid),
        .radicand  (g_sum),
        .pay_in    (g_grad),
        .out_valid (r_valid),
        .root      (r_len),
        .pay_out   (r_grad)
    );

    hmtp_norm_div #(.HB(HB), .LW(RB)) u_ndiv (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (advance),
        .in_valid      (r_valid),
        .len           (r_len),
        .grad          (r_grad),
        .out_valid     (n_valid),
        .normal_x_byte (nx_byte),
        .normal_z_byte (nz_byte)
    );

    // align the short height path with the normal path
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            hb_dly_reg[0] <= h_byte;
            for (int i = 1; i < DLY; i++)
                hb_dly_reg[i] <= hb_dly_reg[i-1];
        end
    end

    assign m_axis_tvalid = n_valid;
    assign m_axis_tdata  = {nz_byte, nx_byte, hb_dly_reg[DLY-1]};

endmodule

// ===== rtl/hmtp_height_div.sv =====
module hmtp_height_div #(
    parameter int HB = hmtp_pkg::HEIGHT_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic signed [HB-1:0]        height_center,
    input  logic signed [HB-1:0]        height_min,
    input  logic signed [HB-1:0]        height_max,
    output logic [hmtp_pkg::BYTE_W-1:0] height_byte
);
    import hmtp_pkg::*;

    localparam int NW = HB + HQ_BITS;

    logic signed [HB:0]   diff_reg;
    logic [HB-1:0]        den_reg;
    logic signed [HB:0]   diff_next;
    logic signed [HB:0]   span_next;

    logic [NW-1:0]        num_reg;
    logic [HB-1:0]        den2_reg;
    logic                 pos_reg;

    logic [NW-1:0]        rem_reg  [HQ_BITS+1];
    logic [HB-1:0]        den3_reg [HQ_BITS+1];
    logic [HQ_BITS-1:0]   q_reg    [HQ_BITS+1];
    logic                 pos3_reg [HQ_BITS+1];
    logic                 sat_reg  [HQ_BITS+1];

    logic [BYTE_W-1:0]    byte_reg;

    always_comb
    begin
        diff_next = HB'(0) + ({height_center[HB-1], height_center}
                    - {height_min[HB-1], height_min});
        span_next = {height_max[HB-1], height_max} - {height_min[HB-1], height_min};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            diff_reg <= diff_next;
            den_reg  <= (span_next < 1) ? HB'(1) : span_next[HB-1:0];
        end
    end

    // 255 * diff as shift minus diff; non-positive differences give zero
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pos_reg  <= (diff_reg > 0);
            num_reg  <= (diff_reg > 0)
                        ? ((NW'(diff_reg[HB-1:0]) << HQ_BITS) - NW'(diff_reg[HB-1:0]))
                        : '0;
            den2_reg <= den_reg;
        end
    end

    // saturation check, then one quotient bit per stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= num_reg;
            den3_reg[0] <= den2_reg;
            q_reg[0]    <= '0;
            pos3_reg[0] <= pos_reg;
            sat_reg[0]  <= (num_reg >= (NW'(den2_reg) << HQ_BITS));
        end
    end

    for (genvar j = 0; j < HQ_BITS; j++)
    begin : g_step
        logic [NW-1:0] dsh;
        logic          ge;

        always_comb
        begin
            dsh = NW'(den3_reg[j]) << (HQ_BITS - 1 - j);
            ge  = (rem_reg[j] >= dsh);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j+1]  <= ge ? (rem_reg[j] - dsh) : rem_reg[j];
                den3_reg[j+1] <= den3_reg[j];
                q_reg[j+1]    <= {q_reg[j][HQ_BITS-2:0], ge};
                pos3_reg[j+1] <= pos3_reg[j];
                sat_reg[j+1]  <= sat_reg[j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            priority if (!pos3_reg[HQ_BITS])
                byte_reg <= '0;
            else if (sat_reg[HQ_BITS])
                byte_reg <= HEIGHT_SAT;
            else
                byte_reg <= q_reg[HQ_BITS];
        end
    end

    assign height_byte = byte_reg;

endmodule

// ===== rtl/hmtp_grad.sv =====
module hmtp_grad #(
    parameter int HB = hmtp_pkg::HEIGHT_BITS_DEF,
    parameter int SW = hmtp_pkg::sum_width(hmtp_pkg::HEIGHT_BITS_DEF)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  hmtp_pkg::pipe_ctl_t           ctl_in,
    input  logic signed [HB-1:0]          height_left,
    input  logic signed [HB-1:0]          height_right,
    input  logic signed [HB-1:0]          height_up,
    input  logic signed [HB-1:0]          height_down,
    input  logic [hmtp_pkg::SCALE_W-1:0]  vertical_scale,
    output logic                          out_valid,
    output logic [SW-1:0]                 sum_sq,
    output logic [2*HB+1:0]               grad
);
    import hmtp_pkg::*;

    logic signed [HB:0] dx_reg, dz_reg;
    logic [HB-1:0]      ax_reg, az_reg, ax3_reg, az3_reg, ax4_reg, az4_reg;
    logic               sx_reg, sz_reg, sx3_reg, sz3_reg, sx4_reg, sz4_reg;
    logic [2*HB-1:0]    sqx_reg, sqz_reg;
    logic [2*SCALE_W-1:0] sqv_reg;
    logic [SW-1:0]      sum_reg;
    logic [GRAD_LAT-1:0] vld_reg;
    logic signed [HB:0] dx_next, dz_next;

    always_comb
    begin
        dx_next = {height_left[HB-1], height_left} - {height_right[HB-1], height_right};
        dz_next = {height_up[HB-1], height_up} - {height_down[HB-1], height_down};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (ctl_in.advance)
            vld_reg <= {vld_reg[GRAD_LAT-2:0], ctl_in.valid};
    end

    always_ff @(posedge clk)
    begin
        if (ctl_in.advance)
        begin
            dx_reg  <= dx_next;
            dz_reg  <= dz_next;
            // magnitude of a difference always fits HB bits
            sx_reg  <= dx_reg[HB];
            sz_reg  <= dz_reg[HB];
            ax_reg  <= dx_reg[HB] ? HB'(-dx_reg) : dx_reg[HB-1:0];
            az_reg  <= dz_reg[HB] ? HB'(-dz_reg) : dz_reg[HB-1:0];
            sqx_reg <= (2*HB)'(ax_reg) * (2*HB)'(ax_reg);
            sqz_reg <= (2*HB)'(az_reg) * (2*HB)'(az_reg);
            sqv_reg <= (2*SCALE_W)'(vertical_scale) * (2*SCALE_W)'(vertical_scale);
            ax3_reg <= ax_reg;
            az3_reg <= az_reg;
            sx3_reg <= sx_reg;
            sz3_reg <= sz_reg;
            sum_reg <= SW'(sqx_reg) + SW'(sqz_reg) + SW'(sqv_reg);
            ax4_reg <= ax3_reg;
            az4_reg <= az3_reg;
            sx4_reg <= sx3_reg;
            sz4_reg <= sz3_reg;
        end
    end

    assign out_valid = vld_reg[GRAD_LAT-1];
    assign sum_sq    = sum_reg;
    // grad fields from the lowest bit: |dz|, |dx|, sign dz, sign dx
    assign grad      = {sx4_reg, sz4_reg, ax4_reg, az4_reg};

endmodule

// ===== rtl/hmtp_isqrt.sv =====
module hmtp_isqrt #(
    parameter int IW = hmtp_pkg::sum_width(hmtp_pkg::HEIGHT_BITS_DEF),
    parameter int PW = 2 * hmtp_pkg::HEIGHT_BITS_DEF + 2,
    parameter int RB = (IW + hmtp_pkg::FRAC_BITS) / 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [IW-1:0]       radicand,
    input  logic [PW-1:0]       pay_in,
    output logic                out_valid,
    output logic [RB-1:0]       root,
    output logic [PW-1:0]       pay_out
);
    import hmtp_pkg::*;

    localparam int RIW = 2 * RB;

    logic [RIW-1:0] rad_reg  [RB];
    logic [RB+1:0]  rem_reg  [RB];
    logic [RB-1:0]  root_reg [RB];
    logic [PW-1:0]  pay_reg  [RB];
    logic           vld_reg  [RB];

    // one root bit per stage, restoring digit-by-digit
    for (genvar i = 0; i < RB; i++)
    begin : g_step
        logic [RIW-1:0] rad_in;
        logic [RB+1:0]  rem_in;
        logic [RB-1:0]  root_in;
        logic [PW-1:0]  p_in;
        logic           v_in;
        logic [RB+1:0]  rem_sh, trial;
        logic           ge;

        if (i == 0)
        begin : g_first
            assign rad_in  = RIW'({radicand, {FRAC_BITS{1'b0}}});
            assign rem_in  = '0;
            assign root_in = '0;
            assign p_in    = pay_in;
            assign v_in    = in_valid;
        end
        else
        begin : g_next
            assign rad_in  = rad_reg[i-1];
            assign rem_in  = rem_reg[i-1];
            assign root_in = root_reg[i-1];
            assign p_in    = pay_reg[i-1];
            assign v_in    = vld_reg[i-1];
        end

        always_comb
        begin
            rem_sh = {rem_in[RB-1:0], rad_in[RIW-1 -: 2]};
            trial  = {root_in, 2'b01};
            ge     = (rem_sh >= trial);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i] <= 1'b0;
            else if (en)
                vld_reg[i] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[i]  <= rad_in << 2;
                rem_reg[i]  <= ge ? (rem_sh - trial) : rem_sh;
                root_reg[i] <= {root_in[RB-2:0], ge};
                pay_reg[i]  <= p_in;
            end
        end
    end

    assign out_valid = vld_reg[RB-1];
    assign root      = root_reg[RB-1];
    assign pay_out   = pay_reg[RB-1];

endmodule

// ===== rtl/hmtp_norm_div.sv =====
module hmtp_norm_div #(
    parameter int HB = hmtp_pkg::HEIGHT_BITS_DEF,
    parameter int LW = 25
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [LW-1:0]               len,
    input  logic [2*HB+1:0]             grad,
    output logic                        out_valid,
    output logic [hmtp_pkg::BYTE_W-1:0] normal_x_byte,
    output logic [hmtp_pkg::BYTE_W-1:0] normal_z_byte
);
    import hmtp_pkg::*;

    localparam int NW = HB + 15;
    localparam int CW = (NW > LW + NQ_BITS) ? NW : LW + NQ_BITS;

    logic [CW-1:0]      remx_reg [NQ_BITS+1];
    logic [CW-1:0]      remz_reg [NQ_BITS+1];
    logic [NQ_BITS-1:0] qx_reg   [NQ_BITS+1];
    logic [NQ_BITS-1:0] qz_reg   [NQ_BITS+1];
    logic [LW-1:0]      len_reg  [NQ_BITS+1];
    logic               sx_reg   [NQ_BITS+1];
    logic               sz_reg   [NQ_BITS+1];
    logic               vld_reg  [NQ_BITS+1];

    logic [HB-1:0]      ax, az;
    logic [BYTE_W-1:0]  nx_reg, nz_reg;
    logic               out_vld_reg;

    assign az = grad[HB-1:0];
    assign ax = grad[2*HB-1:HB];

    // 32512 * |d| = (|d| << 15) - (|d| << 8)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (en)
            vld_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            remx_reg[0] <= (CW'(ax) << 15) - (CW'(ax) << 8);
            remz_reg[0] <= (CW'(az) << 15) - (CW'(az) << 8);
            qx_reg[0]   <= '0;
            qz_reg[0]   <= '0;
            len_reg[0]  <= len;
            sx_reg[0]   <= grad[2*HB+1];
            sz_reg[0]   <= grad[2*HB];
        end
    end

    // len >= 256*|d|, so the quotient is at most 127: seven bits suffice
    for (genvar j = 0; j < NQ_BITS; j++)
    begin : g_step
        logic [CW-1:0] dsh;
        logic          gex, gez;

        always_comb
        begin
            dsh = CW'(len_reg[j]) << (NQ_BITS - 1 - j);
            gex = (remx_reg[j] >= dsh);
            gez = (remz_reg[j] >= dsh);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[j+1] <= 1'b0;
            else if (en)
                vld_reg[j+1] <= vld_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                remx_reg[j+1] <= gex ? (remx_reg[j] - dsh) : remx_reg[j];
                remz_reg[j+1] <= gez ? (remz_reg[j] - dsh) : remz_reg[j];
                qx_reg[j+1]   <= {qx_reg[j][NQ_BITS-2:0], gex};
                qz_reg[j+1]   <= {qz_reg[j][NQ_BITS-2:0], gez};
                len_reg[j+1]  <= len_reg[j];
                sx_reg[j+1]   <= sx_reg[j];
                sz_reg[j+1]   <= sz_reg[j];
            end
        end
    end

    function automatic logic [BYTE_W-1:0] bias_q(input logic neg,
                                                 input logic [NQ_BITS-1:0] q,
                                                 input logic inexact);
        logic [BYTE_W-1:0] qe;
        qe = BYTE_W'(q);
        // negative side rounds the magnitude up (floor of a negative quotient)
        if (neg)
            return NORMAL_BIAS - qe - BYTE_W'(inexact);
        return NORMAL_BIAS + qe;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= vld_reg[NQ_BITS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (len_reg[NQ_BITS] == '0)
            begin
                nx_reg <= NORMAL_BIAS;
                nz_reg <= NORMAL_BIAS;
            end
            else
            begin
                nx_reg <= bias_q(sx_reg[NQ_BITS], qx_reg[NQ_BITS], remx_reg[NQ_BITS] != '0);
                nz_reg <= bias_q(sz_reg[NQ_BITS], qz_reg[NQ_BITS], remz_reg[NQ_BITS] != '0);
            end
        end
    end

    assign out_valid     = out_vld_reg;
    assign normal_x_byte = nx_reg;
    assign normal_z_byte = nz_reg;

endmodule

// ===== rtl/hmtp_checker.sv =====
module hmtp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    // input side opens exactly when the output slot is free or being taken
    a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not track output slot");

    a_normal_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[15:8] != 8'hFF) && (m_axis_tdata[23:16] != 8'hFF))
        else $error("normal byte out of range");

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output item dropped under stall");

    a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output item changed under stall");

endmodule

bind heightmap_texel_packer_unit hmtp_checker u_hmtp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
